/* hdl/stb_pkg.sv */
package stb_pkg;

    localparam int REQ_W      = 4;
    localparam int IDX_W      = 5;
    localparam int TYPE_W     = 4;
    localparam int KEY_W      = 32;
    localparam int PAY_W      = 64;
    localparam int SLOT_W     = 5;
    localparam int TALLY_W    = 6;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 112;

    localparam int FIRST_FREE_SLOT = 2;
    localparam int PUT_SLOT        = 1;
    localparam logic [TYPE_W-1:0] LAST_SEARCH_TYPE = 4'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR      = 4'd0,
        REQ_INSERT     = 4'd1,
        REQ_PUT        = 4'd2,
        REQ_READ       = 4'd3,
        REQ_DELETE     = 4'd4,
        REQ_FIND_TK    = 4'd5,
        REQ_FIRST_TYPE = 4'd6,
        REQ_LAST_TYPE  = 4'd7,
        REQ_FIND_KEY   = 4'd8,
        REQ_COUNT_TYPE = 4'd9,
        REQ_COUNT_ALL  = 4'd10
    } t_req;

endpackage

/* hdl/stb_ram.sv */
module stb_ram #(
    parameter int WIDTH = 100,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

/* hdl/slot_table_with_free_search.sv */
// Slot table with first-free allocation and associative search.
//
// Requests come in on the slave stream: tuser carries the request code,
// tdata the slot index, entry type, key and payload. Each request gives
// exactly one result on the master stream (hit, slot, tally, read fields).
// The entries live in one RAM with a registered read port; a valid bit per
// slot marks entries written since the last clear or delete; an entry
// without it reads as all zero, so reset and clear empty the table at once.
// Steps from acceptance to result, with the output free:
//   clear, delete, undefined codes: straight to the result
//   read, put (read, then write back): one RAM read before the result
//   searches, counts, insert: a sweep of one slot per cycle through the RAM
//   read port; first-match searches and insert stop early.
// One request is in flight at a time; ready is high only while idle, and a
// new request is taken the cycle after the last result is loaded. The
// finished result waits in the output register, so a new request can be
// taken while the receiver stalls; the next result holds until it drains.
// Reset empties the table and drops any pending result.
module slot_table_with_free_search #(
    parameter int SLOTS        = 32,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // slot_index[4:0], entry_type[8:5], entry_key[40:9], entry_payload[104:41]
    input  logic [stb_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // req_type[3:0]
    input  logic [stb_pkg::REQ_W-1:0]        i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // hit[0], found_slot[5:1], tally[11:6], read_type[15:12],
    // read_key[47:16], read_payload[111:48]
    output logic [stb_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    import stb_pkg::*;

    localparam int AW = $clog2(SLOTS);
    localparam int TW = $clog2(SLOTS + 1);
    localparam int WW = TYPE_W + KEY_W + PAYLOAD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PUT,
        S_READ,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [REQ_W-1:0]        r_req;
    logic [IDX_W-1:0]        r_idx;
    logic [TYPE_W-1:0]       r_ety;
    logic [KEY_W-1:0]        r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [AW:0]             r_addr;
    logic [AW-1:0]           r_raddr;
    logic                    r_issue;
    logic                    r_rvalid;
    logic [SLOTS-1:0]        r_valid;
    logic                    r_hit;
    logic [AW-1:0]           r_slot;
    logic [TW-1:0]           r_tally;
    logic [TYPE_W-1:0]       r_rt;
    logic [KEY_W-1:0]        r_rk;
    logic [PAYLOAD_BITS-1:0] r_rp;
    logic                    r_m_valid;
    logic [OUT_DATA_W-1:0]   r_m_data;

    logic [IDX_W-1:0]        in_idx;
    logic [TYPE_W-1:0]       in_ety;
    logic [KEY_W-1:0]        in_key;
    logic [PAY_W-1:0]        in_pay;
    logic                    s_acc;
    logic                    in_idx_ok;
    logic                    m_load;

    logic [AW-1:0]           rd_addr;
    logic [WW-1:0]           rd_word;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [WW-1:0]           ram_wdata;

    logic [TYPE_W-1:0]       e_type;
    logic [KEY_W-1:0]        e_key;
    logic [PAYLOAD_BITS-1:0] e_pay;
    logic                    tm;
    logic                    km;
    logic                    match;
    logic                    first_req;

    assign in_idx = i_s_axis_tdata[4:0];
    assign in_ety = i_s_axis_tdata[8:5];
    assign in_key = i_s_axis_tdata[40:9];
    assign in_pay = i_s_axis_tdata[104:41];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign in_idx_ok       = int'(in_idx) < SLOTS;
    assign m_load          = (r_state == S_DONE) && (!r_m_valid || i_m_axis_tready);

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

    // read address: request setup while idle, sweep counter in the other states
    always_comb begin
        rd_addr = '0;
        if (r_state == S_IDLE) begin
            case (i_s_axis_tuser)
                REQ_PUT:    rd_addr = AW'(PUT_SLOT);
                REQ_READ:   rd_addr = in_idx_ok ? AW'(in_idx) : '0;
                REQ_INSERT: rd_addr = AW'(FIRST_FREE_SLOT);
                default:    rd_addr = '0;
            endcase
        end else if (int'(r_addr) < SLOTS) begin
            rd_addr = r_addr[AW-1:0];
        end
    end

    // entries not written since the last clear or delete read as empty
    assign e_type = r_rvalid ? rd_word[TYPE_W-1:0] : '0;
    assign e_key  = r_rvalid ? rd_word[TYPE_W +: KEY_W] : '0;
    assign e_pay  = r_rvalid ? rd_word[TYPE_W + KEY_W +: PAYLOAD_BITS] : '0;

    assign tm = (e_type == r_ety);
    assign km = (e_key == r_key);

    always_comb begin
        match     = 1'b0;
        first_req = 1'b0;
        case (r_req) inside
            REQ_INSERT: begin
                match     = (e_type == '0);
                first_req = 1'b1;
            end
            REQ_FIND_TK: begin
                match     = tm && km;
                first_req = 1'b1;
            end
            REQ_FIRST_TYPE: begin
                match     = tm;
                first_req = 1'b1;
            end
            REQ_FIND_KEY: begin
                match     = km;
                first_req = 1'b1;
            end
            REQ_LAST_TYPE:  match = (e_type == LAST_SEARCH_TYPE);
            REQ_COUNT_TYPE: match = tm;
            REQ_COUNT_ALL:  match = (e_type != '0);
            default:        match = 1'b0;
        endcase
    end

    assign ram_we    = (r_state == S_PUT) ||
                       (r_state == S_SCAN && r_issue && r_req == REQ_INSERT && match);
    assign ram_waddr = (r_state == S_PUT) ? AW'(PUT_SLOT) : r_raddr;
    assign ram_wdata = {r_pay, r_key, r_ety};

    stb_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_issue   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_raddr  <= rd_addr;
            r_rvalid <= r_valid[rd_addr];

            if (m_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_req   <= i_s_axis_tuser;
                        r_idx   <= in_idx;
                        r_ety   <= in_ety;
                        r_key   <= in_key;
                        r_pay   <= in_pay[PAYLOAD_BITS-1:0];
                        r_hit   <= 1'b0;
                        r_slot  <= '0;
                        r_tally <= '0;
                        r_rt    <= '0;
                        r_rk    <= '0;
                        r_rp    <= '0;
                        case (i_s_axis_tuser) inside
                            REQ_CLEAR: begin
                                r_valid <= '0;
                                r_state <= S_DONE;
                            end
                            REQ_DELETE: begin
                                if (in_idx_ok) begin
                                    r_valid[AW'(in_idx)] <= 1'b0;
                                end
                                r_state <= S_DONE;
                            end
                            REQ_PUT: begin
                                r_state <= S_PUT;
                            end
                            REQ_READ: begin
                                r_state <= S_READ;
                            end
                            REQ_INSERT: begin
                                r_addr  <= (AW + 1)'(FIRST_FREE_SLOT + 1);
                                r_issue <= 1'b1;
                                r_state <= S_SCAN;
                            end
                            REQ_FIND_TK, REQ_FIRST_TYPE, REQ_LAST_TYPE, REQ_FIND_KEY,
                            REQ_COUNT_TYPE, REQ_COUNT_ALL: begin
                                r_addr  <= (AW + 1)'(1);
                                r_issue <= 1'b1;
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // advance the sweep while the previous read comes back
                    if (int'(r_addr) < SLOTS) begin
                        r_addr  <= r_addr + (AW + 1)'(1);
                        r_issue <= 1'b1;
                    end else begin
                        r_issue <= 1'b0;
                    end
                    if (r_issue) begin
                        if (match) begin
                            if (first_req) begin
                                r_hit  <= 1'b1;
                                r_slot <= r_raddr;
                                if (r_req == REQ_INSERT) begin
                                    r_valid[r_raddr] <= 1'b1;
                                end
                            end else if (r_req == REQ_LAST_TYPE) begin
                                r_hit  <= 1'b1;
                                r_slot <= r_raddr;
                            end else begin
                                r_tally <= r_tally + TW'(1);
                            end
                        end
                        if ((match && first_req) || int'(r_raddr) == SLOTS - 1) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_PUT: begin
                    r_hit             <= (e_type != '0);
                    r_slot            <= AW'(PUT_SLOT);
                    r_valid[PUT_SLOT] <= 1'b1;
                    r_state           <= S_DONE;
                end
                S_READ: begin
                    if (int'(r_idx) < SLOTS) begin
                        r_hit  <= 1'b1;
                        r_slot <= AW'(r_idx);
                        r_rt   <= e_type;
                        r_rk   <= e_key;
                        r_rp   <= e_pay;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_issue <= 1'b0;
                    // hold the result until the output register is free
                    if (m_load) begin
                        r_m_data  <= {PAY_W'(r_rp), r_rk, r_rt, TALLY_W'(r_tally),
                                      SLOT_W'(r_slot), r_hit};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tuser == REQ_CLEAR) |=> (r_valid == '0))
        else $error("valid bits not cleared after clear request");

    a_no_write_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (ram_waddr != '0))
        else $error("RAM write to slot 0");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_issue) |-> (int'(r_raddr) < SLOTS))
        else $error("scan read beyond table");

    a_miss_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !r_m_data[0]) |->
            (r_m_data[5:1] == SLOT_W'(0) || r_m_data[5:1] == SLOT_W'(PUT_SLOT)))
        else $error("miss result carries a slot number");

    a_tally_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_data[11:6] != TALLY_W'(0)) |-> !r_m_data[0])
        else $error("count result with hit set");

endmodule

/* dv/slot_table_with_free_search_tb.sv */
`timescale 1ns / 1ps

module slot_table_with_free_search_tb;
    import stb_pkg::*;

    localparam int SLOTS        = 32;
    localparam int N_ITEMS      = 1650;
    localparam int MAX_GAP      = 5;
    localparam int DRAIN_CYCLES = SLOTS + 8;
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int KEY_POOL_N   = 6;

    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 4'd11;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 4'd15;

    typedef struct packed {
        logic [REQ_W-1:0]  code;
        logic [PAY_W-1:0]  pay;
        logic [KEY_W-1:0]  key;
        logic [TYPE_W-1:0] etype;
        logic [IDX_W-1:0]  idx;
    } t_request;

    // packed from the top down so that hit lands in bit 0 of tdata
    typedef struct packed {
        logic [PAY_W-1:0]   rpay;
        logic [KEY_W-1:0]   rkey;
        logic [TYPE_W-1:0]  rtype;
        logic [TALLY_W-1:0] tally;
        logic [SLOT_W-1:0]  slot;
        logic               hit;
    } t_result;

    typedef struct {
        t_request rq;
        bit       typed;
        t_result  res;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_axis_tvalid;
    logic                    o_s_axis_tready;
    logic [IN_DATA_W-1:0]    i_s_axis_tdata;
    logic [REQ_W-1:0]        i_s_axis_tuser;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready;
    logic [OUT_DATA_W-1:0]   o_m_axis_tdata;

    slot_table_with_free_search #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAY_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow copy of the table
    logic [TYPE_W-1:0] tbl_type [SLOTS];
    logic [KEY_W-1:0]  tbl_key  [SLOTS];
    logic [PAY_W-1:0]  tbl_pay  [SLOTS];

    t_result     expected_results [$];
    t_row        directed_rows [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_N];
    int unsigned errors;
    int unsigned n_sent;
    int unsigned cycle_count;
    int          stall_left;
    bit          idle_enabled;
    t_result     want_res;
    t_result     got_res;

    function automatic void store_entry(int s, t_request r);
        tbl_type[s] = r.etype;
        tbl_key[s]  = r.key;
        tbl_pay[s]  = r.pay;
    endfunction

    function automatic t_result table_apply(t_request r);
        t_result res;
        int      s;
        bit      type_eq;
        bit      key_eq;
        bit      matched;
        res = '0;
        case (r.code)
            REQ_CLEAR: begin
                for (s = 0; s < SLOTS; s++) begin
                    tbl_type[s] = '0;
                    tbl_key[s]  = '0;
                    tbl_pay[s]  = '0;
                end
            end
            REQ_INSERT: begin
                for (s = FIRST_FREE_SLOT; s < SLOTS && !res.hit; s++) begin
                    if (tbl_type[s] == '0) begin
                        store_entry(s, r);
                        res.hit  = 1'b1;
                        res.slot = SLOT_W'(s);
                    end
                end
            end
            REQ_PUT: begin
                res.hit  = (tbl_type[PUT_SLOT] != '0);
                res.slot = SLOT_W'(PUT_SLOT);
                store_entry(PUT_SLOT, r);
            end
            REQ_READ: begin
                if (int'(r.idx) < SLOTS) begin
                    res.hit   = 1'b1;
                    res.slot  = r.idx;
                    res.rtype = tbl_type[r.idx];
                    res.rkey  = tbl_key[r.idx];
                    res.rpay  = tbl_pay[r.idx];
                end
            end
            REQ_DELETE: begin
                if (int'(r.idx) < SLOTS) begin
                    tbl_type[r.idx] = '0;
                    tbl_key[r.idx]  = '0;
                    tbl_pay[r.idx]  = '0;
                end
            end
            REQ_FIND_TK, REQ_FIRST_TYPE, REQ_FIND_KEY: begin
                for (s = 0; s < SLOTS && !res.hit; s++) begin
                    type_eq = (tbl_type[s] == r.etype);
                    key_eq  = (tbl_key[s] == r.key);
                    if (r.code == REQ_FIND_TK)
                        matched = type_eq && key_eq;
                    else if (r.code == REQ_FIRST_TYPE)
                        matched = type_eq;
                    else
                        matched = key_eq;
                    if (matched) begin
                        res.hit  = 1'b1;
                        res.slot = SLOT_W'(s);
                    end
                end
            end
            REQ_LAST_TYPE: begin
                // the requested type plays no part here
                for (s = 0; s < SLOTS; s++) begin
                    if (tbl_type[s] == LAST_SEARCH_TYPE) begin
                        res.hit  = 1'b1;
                        res.slot = SLOT_W'(s);
                    end
                end
            end
            REQ_COUNT_TYPE: begin
                for (s = 0; s < SLOTS; s++)
                    if (tbl_type[s] == r.etype)
                        res.tally++;
            end
            REQ_COUNT_ALL: begin
                for (s = 0; s < SLOTS; s++)
                    if (tbl_type[s] != '0)
                        res.tally++;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void add_row(logic [REQ_W-1:0] code, logic [IDX_W-1:0] idx,
                                    logic [TYPE_W-1:0] etype, logic [KEY_W-1:0] key,
                                    logic [PAY_W-1:0] pay, bit typed, logic hit,
                                    logic [SLOT_W-1:0] slot, logic [TALLY_W-1:0] tally);
        t_row rw;
        rw.rq.code  = code;
        rw.rq.idx   = idx;
        rw.rq.etype = etype;
        rw.rq.key   = key;
        rw.rq.pay   = pay;
        rw.typed    = typed;
        rw.res      = '0;
        rw.res.hit  = hit;
        rw.res.slot = slot;
        rw.res.tally = tally;
        directed_rows.push_back(rw);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
        return $urandom;
    endfunction

    function automatic logic [TYPE_W-1:0] pick_type();
        if ($urandom_range(0, 9) < 7)
            return TYPE_W'($urandom_range(0, 3));
        return TYPE_W'($urandom_range(0, 15));
    endfunction

    function automatic t_request random_request(logic [REQ_W-1:0] code);
        t_request r;
        r.code  = code;
        r.idx   = IDX_W'($urandom_range(0, SLOTS - 1));
        r.etype = pick_type();
        r.key   = pick_key();
        r.pay   = {$urandom, $urandom};
        return r;
    endfunction

    function automatic logic [REQ_W-1:0] pick_code();
        int w;
        w = $urandom_range(0, 99);
        if (w < 14) return REQ_READ;
        if (w < 22) return REQ_DELETE;
        if (w < 34) return REQ_FIND_TK;
        if (w < 44) return REQ_FIRST_TYPE;
        if (w < 51) return REQ_LAST_TYPE;
        if (w < 63) return REQ_FIND_KEY;
        if (w < 71) return REQ_COUNT_TYPE;
        if (w < 76) return REQ_COUNT_ALL;
        if (w < 88) return REQ_INSERT;
        if (w < 93) return REQ_PUT;
        if (w < 98) return REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
        return REQ_CLEAR;
    endfunction

    // entered and left at a falling edge
    task automatic send_request(t_request r, bit typed, t_result typed_res);
        int      gap;
        t_result predicted;
        gap = idle_enabled ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= r.code;
        i_s_axis_tdata  <= IN_DATA_W'({r.pay, r.key, r.etype, r.idx});
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        predicted = table_apply(r);
        expected_results.push_back(typed ? typed_res : predicted);
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic void check_field(string what, logic [PAY_W-1:0] want,
                                        logic [PAY_W-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            stall_left = idle_enabled ? $urandom_range(0, MAX_GAP) : 0;
            got_res = t_result'(o_m_axis_tdata);
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, expected none actual %h",
                         $time, o_m_axis_tdata);
            end else begin
                want_res = expected_results.pop_front();
                check_field("hit", PAY_W'(want_res.hit), PAY_W'(got_res.hit));
                check_field("found_slot", PAY_W'(want_res.slot), PAY_W'(got_res.slot));
                check_field("tally", PAY_W'(want_res.tally), PAY_W'(got_res.tally));
                check_field("read_type", PAY_W'(want_res.rtype), PAY_W'(got_res.rtype));
                check_field("read_key", PAY_W'(want_res.rkey), PAY_W'(got_res.rkey));
                check_field("read_payload", want_res.rpay, got_res.rpay);
            end
        end
    end

    // hold ready low for the stall drawn at the last result
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        t_request r;
        int       fill;
        int       mix;
        int       i;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        idle_enabled    = 1'b1;
        stall_left      = 0;
        errors          = 0;
        n_sent          = 0;
        cycle_count     = 0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < KEY_POOL_N; i++)
            key_pool[i] = $urandom;
        r = '0;
        r.code = REQ_CLEAR;
        void'(table_apply(r));

        add_row(REQ_COUNT_ALL,    0,  0,  0,            0,  1, 0, 0,  0);
        add_row(REQ_FIND_KEY,     0,  0,  0,            0,  1, 1, 0,  0);
        add_row(REQ_FIRST_TYPE,   7,  0,  32'hDEAD_BEEF, 0, 1, 1, 0,  0);
        add_row(REQ_LAST_TYPE,    0,  9,  0,            0,  1, 0, 0,  0);
        add_row(REQ_READ,         31, 0,  0,            0,  1, 1, 31, 0);
        add_row(REQ_UNUSED_LAST,  31, 15, '1,           '1, 1, 0, 0,  0);
        add_row(REQ_PUT,          0,  15, '1,           '1, 1, 0, 1,  0);
        add_row(REQ_PUT,          0,  1,  0,            0,  1, 1, 1,  0);
        // an empty-type insert leaves slot 2 free for the next one
        add_row(REQ_INSERT,       0,  0,  32'h1234_5678, 64'h0123_4567_89AB_CDEF,
                1, 1, 2, 0);
        add_row(REQ_INSERT,       31, 1,  '1,           '1, 1, 1, 2,  0);
        add_row(REQ_INSERT,       0,  15, 0,            64'h8000_0000_0000_0001,
                1, 1, 3, 0);
        add_row(REQ_READ,         2,  0,  0,            0,  0, 0, 0,  0);
        add_row(REQ_FIND_TK,      0,  15, 0,            0,  0, 0, 0,  0);
        add_row(REQ_FIND_KEY,     0,  0,  '1,           0,  0, 0, 0,  0);
        add_row(REQ_FIRST_TYPE,   0,  1,  0,            0,  0, 0, 0,  0);
        add_row(REQ_LAST_TYPE,    0,  15, 0,            0,  0, 0, 0,  0);
        add_row(REQ_COUNT_TYPE,   0,  1,  0,            0,  0, 0, 0,  0);
        add_row(REQ_COUNT_TYPE,   0,  0,  0,            0,  0, 0, 0,  0);
        add_row(REQ_DELETE,       2,  0,  0,            0,  0, 0, 0,  0);
        add_row(REQ_DELETE,       0,  0,  0,            0,  0, 0, 0,  0);
        add_row(REQ_READ,         2,  0,  0,            0,  0, 0, 0,  0);
        add_row(REQ_UNUSED_FIRST, 5,  3,  32'hA5A5_A5A5, '1, 1, 0, 0,  0);
        add_row(REQ_CLEAR,        0,  0,  0,            0,  1, 0, 0,  0);
        add_row(REQ_COUNT_ALL,    0,  0,  0,            0,  1, 0, 0,  0);
        add_row(REQ_COUNT_TYPE,   0,  0,  0,            0,  1, 0, 0,  32);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            send_request(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].res);

        // random episodes: optional clear, a burst of allocations, then mixed traffic
        while (n_sent < N_ITEMS) begin
            idle_enabled = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                send_request(random_request(REQ_CLEAR), 1'b0, '0);
            fill = $urandom_range(0, 1) ? $urandom_range(20, 36) : $urandom_range(0, 8);
            for (i = 0; i < fill && n_sent < N_ITEMS; i++) begin
                r = random_request(($urandom_range(0, 7) == 0) ? REQ_PUT : REQ_INSERT);
                if ($urandom_range(0, 9) != 0)
                    r.etype = TYPE_W'($urandom_range(1, 3));
                send_request(r, 1'b0, '0);
            end
            mix = $urandom_range(10, 40);
            for (i = 0; i < mix && n_sent < N_ITEMS; i++)
                send_request(random_request(pick_code()), 1'b0, '0);
        end
        i_s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
hdl/stb_pkg.sv
hdl/stb_ram.sv
hdl/slot_table_with_free_search.sv
dv/slot_table_with_free_search_tb.sv
